// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command, payload and status types, control character codes, state codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS_DEF       = 80;
  localparam int ROWS_DEF       = 25;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ACTION_W = 2;
  localparam int RD_ROW_W = 5;
  localparam int RD_COL_W = 7;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_VAL_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h00;
  localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h07;

  localparam logic [ATTR_W-1:0] TAB_COLOR_RST  = 8'h07;
  localparam logic [CNT_W-1:0]  TAB_SPACES_RST = 4'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAB_COLOR  = 1'b0,
    REG_TAB_SPACES = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_LF,
    ST_SC_RD,
    ST_SC_WR,
    ST_FILL,
    ST_WIPE,
    ST_BS,
    ST_BS_RD,
    ST_BS_WR,
    ST_RD_A,
    ST_RD_D,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [ATTR_W-1:0]   attr;
    logic [RD_ROW_W-1:0] read_row;
    logic [RD_COL_W-1:0] read_col;
  } in_data_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic [CUR_COL_W-1:0] cur_col;
    logic [CUR_ROW_W-1:0] cur_row;
  } out_data_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_data_t;

  typedef struct packed {
    op_e                 op;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   attr;
    logic [CNT_W-1:0]    count;
    logic [RD_ROW_W-1:0] rd_row;
    logic [RD_COL_W-1:0] rd_col;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } bk_status_t;

endpackage

// File: src/tcw_stream_if.sv
// ----------------------------------------------------------------------------
// tcw_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface tcw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: input classifier and configuration registers
// Accepts input transactions, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcw_stream_if.sink          in_i,
  tcw_stream_if.sink          cfg_i,
  input  tcw_pkg::bk_status_t status_i,
  input  logic                fifo_full_i,
  output logic                push_o,
  output tcw_pkg::cmd_t       cmd_o
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] tab_color_q;
  logic [CNT_W-1:0]  tab_spaces_q;
  logic              in_range;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_color_q  <= TAB_COLOR_RST;
      tab_spaces_q <= TAB_SPACES_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_TAB_COLOR:  tab_color_q  <= cfg_i.data.value;
        REG_TAB_SPACES: tab_spaces_q <= cfg_i.data.value[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !fifo_full_i && !status_i.init_busy;
  assign push_o     = in_i.valid && in_i.ready;

  assign in_range = (32'(in_i.data.read_row) < ROWS) && (32'(in_i.data.read_col) < COLS);

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = OP_NOP;
    cmd_o.ch     = in_i.data.char_code;
    cmd_o.attr   = in_i.data.attr;
    cmd_o.rd_row = in_i.data.read_row;
    cmd_o.rd_col = in_i.data.read_col;
    unique case (in_i.data.action)
      ACT_PUT: begin
        unique case (in_i.data.char_code)
          CHAR_LF: cmd_o.op = OP_NEWLINE;
          CHAR_BS: cmd_o.op = OP_BACKSPACE;
          CHAR_TAB: begin
            cmd_o.op    = (tab_spaces_q == '0) ? OP_NOP : OP_WRITE;
            cmd_o.ch    = CHAR_SPACE;
            cmd_o.attr  = tab_color_q;
            cmd_o.count = tab_spaces_q;
          end
          default: begin
            cmd_o.op    = OP_WRITE;
            cmd_o.count = CNT_W'(1);
          end
        endcase
      end
      ACT_CLEAR: cmd_o.op = OP_CLEAR;
      ACT_READ:  cmd_o.op = in_range ? OP_READ : OP_NOP;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// File: src/tcw_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tcw_cmd_fifo: command queue
// Short first-in first-out queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output tcw_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import tcw_pkg::*;

  localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;

  cmd_t            entry_q [CMD_FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     fill_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (fill_q == (PW+1)'(CMD_FIFO_DEPTH));
  assign empty_o = (fill_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      fill_q <= fill_q + (PW+1)'(1);
      else if (pop_i && !push_i) fill_q <= fill_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

// File: src/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: command executor
// Owns the screen memory and cursor, runs writes, backspaces, scrolls, wipes and reads,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcw_pkg::cmd_t       cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  output tcw_pkg::bk_status_t status_o,
  tcw_stream_if.source        out_o
);
  import tcw_pkg::*;

  localparam int DEPTH    = ROWS * COLS;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(COLS);
  localparam int RW       = $clog2(ROWS);
  localparam int LAST_ROW = (ROWS - 1) * COLS;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  st_e               state_q, state_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              init_q, init_d;
  logic              ovalid_q, ovalid_d;
  cmd_t              cmd_q, cmd_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  out_data_t         odata_q, odata_d;

  logic [CELL_W-1:0] mem [DEPTH];
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata_q;
  logic [AW-1:0]     cur_addr, rd_addr;

  assign cur_addr = AW'(row_q) * AW'(COLS) + AW'(col_q);
  assign rd_addr  = AW'(cmd_q.rd_row) * AW'(COLS) + AW'(cmd_q.rd_col);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    init_d    = init_q;
    cmd_d     = cmd_q;
    cell_d    = cell_q;
    odata_d   = odata_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = cur_addr;
    wdata     = '0;
    raddr     = cur_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cell_d    = '0;
          rem_d     = cmd_i.count;
          cnt_d     = '0;
          unique case (cmd_i.op)
            OP_WRITE:     state_d = ST_WRITE;
            OP_NEWLINE:   state_d = ST_LF;
            OP_BACKSPACE: state_d = ST_BS;
            OP_CLEAR:     state_d = ST_WIPE;
            OP_READ:      state_d = ST_RD_A;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_WRITE: begin
        we    = 1'b1;
        wdata = {cmd_q.attr, cmd_q.ch};
        rem_d = rem_q - CNT_W'(1);
        if (col_q == CW'(COLS - 1)) begin
          col_d = '0;
          if (row_q == RW'(ROWS - 1)) begin
            cnt_d   = '0;
            state_d = ST_SC_RD;
          end else begin
            row_d   = row_q + RW'(1);
            state_d = (rem_q == CNT_W'(1)) ? ST_DONE : ST_WRITE;
          end
        end else begin
          col_d   = col_q + CW'(1);
          state_d = (rem_q == CNT_W'(1)) ? ST_DONE : ST_WRITE;
        end
      end
      ST_LF: begin
        col_d = '0;
        if (row_q == RW'(ROWS - 1)) begin
          cnt_d   = '0;
          state_d = ST_SC_RD;
        end else begin
          row_d   = row_q + RW'(1);
          state_d = ST_DONE;
        end
      end
      ST_SC_RD: begin
        raddr   = cnt_q + AW'(COLS);
        state_d = ST_SC_WR;
      end
      ST_SC_WR: begin
        we      = 1'b1;
        waddr   = cnt_q;
        wdata   = rdata_q;
        cnt_d   = cnt_q + AW'(1);
        state_d = (cnt_q == AW'(LAST_ROW - 1)) ? ST_FILL : ST_SC_RD;
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {ATTR_DEFAULT, CHAR_SPACE};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          state_d = (rem_q == '0) ? ST_DONE : ST_WRITE;
        end
      end
      ST_WIPE: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {ATTR_DEFAULT, CHAR_BLANK};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(DEPTH - 1)) begin
          col_d   = '0;
          row_d   = '0;
          init_d  = 1'b0;
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_BS: begin
        if (col_q == '0 && row_q == '0) begin
          state_d = ST_DONE;
        end else begin
          if (col_q == '0) begin
            row_d = row_q - RW'(1);
            col_d = CW'(COLS - 1);
          end else begin
            col_d = col_q - CW'(1);
          end
          state_d = ST_BS_RD;
        end
      end
      ST_BS_RD: state_d = ST_BS_WR;
      ST_BS_WR: begin
        we      = 1'b1;
        wdata   = {rdata_q[CELL_W-1:CHAR_W], CHAR_BLANK};
        state_d = ST_DONE;
      end
      ST_RD_A: begin
        raddr   = rd_addr;
        state_d = ST_RD_D;
      end
      ST_RD_D: begin
        cell_d  = rdata_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d          = 1'b1;
          odata_d.cell_char = cell_q[CHAR_W-1:0];
          odata_d.cell_attr = cell_q[CELL_W-1:CHAR_W];
          odata_d.cur_col   = CUR_COL_W'(col_q);
          odata_d.cur_row   = CUR_ROW_W'(row_q);
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WIPE;
      col_q    <= '0;
      row_q    <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
      init_q   <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      init_q   <= init_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cell_q  <= cell_d;
    odata_q <= odata_d;
  end

  assign status_o.init_busy = init_q;
  assign out_o.valid        = ovalid_q;
  assign out_o.data         = odata_q;

endmodule

// File: src/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: text screen writer with cursor
//
//   channel | dir | payload                                    | accepted when
//   in_i    | in  | action, char_code, attr, read_row, read_col | valid && ready
//   out_o   | out | cell_char, cell_attr, cur_col, cur_row      | valid && ready
//   cfg_i   | in  | index (0 tab_color, 1 tab_spaces), value    | valid && ready
//
// A wrap or newline on the bottom row adds a scroll of the screen; clear
// rewrites all ROWS*COLS cells of the screen memory. After reset a wipe of
// all ROWS*COLS cells runs before the first input transaction; config
// writes are taken meanwhile. A two-entry command queue and the output
// register let input and output stall on their own.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcw_stream_if.sink   in_i,
  tcw_stream_if.source out_o,
  tcw_stream_if.sink   cfg_i
);
  import tcw_pkg::*;

  cmd_t       front_cmd, back_cmd;
  logic       push, pop, fifo_full, fifo_empty;
  bk_status_t bk_status;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .status_i    (bk_status),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tcw_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .cmd_o   (back_cmd),
    .empty_o (fifo_empty)
  );

  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!fifo_empty),
    .cmd_pop_o   (pop),
    .status_o    (bk_status),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full) else $error("push into full command queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_empty) else $error("pop from empty command queue");

  a_no_accept_wipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !bk_status.init_busy)
    else $error("input transaction accepted during reset wipe");
`endif

endmodule

// File: tb/text_console_writer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_checker: screen and cursor predictor with result check
// Watches the command, result and register channels of the console writer.
// Each accepted command is applied to a private copy of the screen, cursor
// and tab settings. The expected cell and cursor go into a queue, and every
// result transaction is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  tcw_pkg::in_data_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  tcw_pkg::out_data_t             out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  tcw_pkg::cfg_data_t             cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    scroll_count_o,
  output int unsigned                    read_count_o,
  output logic [tcw_pkg::CUR_COL_W-1:0]  cursor_col_o,
  output logic [tcw_pkg::CUR_ROW_W-1:0]  cursor_row_o
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0]    glyph [ROWS][COLS];
  logic [ATTR_W-1:0]    color [ROWS][COLS];
  logic [CUR_COL_W-1:0] col_pos;
  logic [CUR_ROW_W-1:0] row_pos;
  logic [ATTR_W-1:0]    tab_attr;
  logic [CNT_W-1:0]     tab_len;
  out_data_t            cell_q[$];
  out_data_t            oldest;
  int unsigned          fail_total;
  int unsigned          checked_total;
  int unsigned          scroll_total;
  int unsigned          read_total;

  function void feed_line();
    if (int'(row_pos) < ROWS - 1) begin
      row_pos++;
    end else begin
      for (int r = 0; r < ROWS - 1; r++) begin
        for (int c = 0; c < COLS; c++) begin
          glyph[r][c] = glyph[r+1][c];
          color[r][c] = color[r+1][c];
        end
      end
      for (int c = 0; c < COLS; c++) begin
        glyph[ROWS-1][c] = CHAR_SPACE;
        color[ROWS-1][c] = ATTR_DEFAULT;
      end
      scroll_total++;
    end
    col_pos = '0;
  endfunction

  function void put_glyph(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] at);
    glyph[row_pos][col_pos] = ch;
    color[row_pos][col_pos] = at;
    col_pos++;
    if (int'(col_pos) >= COLS) feed_line();
  endfunction

  function void rub_out();
    if (col_pos != 0 || row_pos != 0) begin
      if (col_pos == 0) begin
        row_pos--;
        col_pos = CUR_COL_W'(COLS - 1);
      end else begin
        col_pos--;
      end
      glyph[row_pos][col_pos] = CHAR_BLANK;
    end
  endfunction

  function void wipe_screen();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        glyph[r][c] = CHAR_BLANK;
        color[r][c] = ATTR_DEFAULT;
      end
    end
    col_pos = '0;
    row_pos = '0;
  endfunction

  function out_data_t apply_command(input in_data_t cmd);
    out_data_t res;
    res = '0;
    case (cmd.action)
      ACT_PUT: begin
        if (cmd.char_code == CHAR_LF) begin
          feed_line();
        end else if (cmd.char_code == CHAR_TAB) begin
          for (int i = 0; i < int'(tab_len); i++) put_glyph(CHAR_SPACE, tab_attr);
        end else if (cmd.char_code == CHAR_BS) begin
          rub_out();
        end else begin
          put_glyph(cmd.char_code, cmd.attr);
        end
      end
      ACT_CLEAR: wipe_screen();
      ACT_READ: begin
        read_total++;
        if (int'(cmd.read_row) < ROWS && int'(cmd.read_col) < COLS) begin
          res.cell_char = glyph[cmd.read_row][cmd.read_col];
          res.cell_attr = color[cmd.read_row][cmd.read_col];
        end
      end
      default: ;
    endcase
    res.cur_col = col_pos;
    res.cur_row = row_pos;
    return res;
  endfunction

  task report_mismatch(input string msg);
    fail_total++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task check_cell(input out_data_t got, input out_data_t exp);
    if (got.cell_char !== exp.cell_char)
      report_mismatch($sformatf("cell_char got %0h expected %0h", got.cell_char, exp.cell_char));
    if (got.cell_attr !== exp.cell_attr)
      report_mismatch($sformatf("cell_attr got %0h expected %0h", got.cell_attr, exp.cell_attr));
    if (got.cur_col !== exp.cur_col)
      report_mismatch($sformatf("cur_col got %0d expected %0d", got.cur_col, exp.cur_col));
    if (got.cur_row !== exp.cur_row)
      report_mismatch($sformatf("cur_row got %0d expected %0d", got.cur_row, exp.cur_row));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_screen();
      tab_attr = TAB_COLOR_RST;
      tab_len = TAB_SPACES_RST;
      cell_q.delete();
      fail_total = 0;
      checked_total = 0;
      scroll_total = 0;
      read_total = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.index)
          REG_TAB_COLOR:  tab_attr = cfg_data_i.value;
          REG_TAB_SPACES: tab_len = cfg_data_i.value[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (cell_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: char %0h attr %0h cursor %0d,%0d",
                                    out_data_i.cell_char, out_data_i.cell_attr,
                                    out_data_i.cur_row, out_data_i.cur_col));
        end else begin
          oldest = cell_q.pop_front();
          check_cell(out_data_i, oldest);
        end
        checked_total++;
      end
      if (in_valid_i && in_ready_i) cell_q.push_back(apply_command(in_data_i));
    end
    fail_count_o   <= fail_total;
    pending_o      <= cell_q.size();
    checked_o      <= checked_total;
    scroll_count_o <= scroll_total;
    read_count_o   <= read_total;
    cursor_col_o   <= col_pos;
    cursor_row_o   <= row_pos;
  end

endmodule

// File: tb/text_console_writer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_unit_test: stimulus and verdict for the console writer
// Runs a short directed sequence through every action, control character and
// read-range corner, then random phases under different tab settings with
// bursty commands, a patterned result stall and one long result hold-off.
// A separate checker predicts every result; a watchdog bounds idle time.
// ----------------------------------------------------------------------------
module text_console_writer_unit_test;
  import tcw_pkg::*;

  localparam int          CLK_PERIOD      = 10;
  localparam int          RESET_CYCLES    = 11;
  localparam int          HOLD_OFF_CYCLES = 1500;
  localparam int          IDLE_LIMIT      = 60000;
  localparam int          TAIL_CYCLES     = 50;
  localparam int          PHASE_ITEMS     = 190;
  localparam int          NUM_PHASES      = 6;
  localparam logic [1:0]  ACT_SPARE       = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_off_req = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned scrolls;
  int unsigned reads;
  logic [CUR_COL_W-1:0] hint_col;
  logic [CUR_ROW_W-1:0] hint_row;

  int unsigned burst_left = 0;
  int unsigned sent_total = 0;
  int unsigned reg_writes = 0;

  tcw_stream_if #(.T(in_data_t))  cmd_ch ();
  tcw_stream_if #(.T(out_data_t)) cell_ch ();
  tcw_stream_if #(.T(cfg_data_t)) reg_ch ();

  text_console_writer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (cell_ch),
    .cfg_i  (reg_ch)
  );

  text_console_writer_checker #(
    .COLS (COLS_DEF),
    .ROWS (ROWS_DEF)
  ) screen_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (cmd_ch.valid),
    .in_ready_i     (cmd_ch.ready),
    .in_data_i      (cmd_ch.data),
    .out_valid_i    (cell_ch.valid),
    .out_ready_i    (cell_ch.ready),
    .out_data_i     (cell_ch.data),
    .cfg_valid_i    (reg_ch.valid),
    .cfg_ready_i    (reg_ch.ready),
    .cfg_data_i     (reg_ch.data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .scroll_count_o (scrolls),
    .read_count_o   (reads),
    .cursor_col_o   (hint_col),
    .cursor_row_o   (hint_row)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;
    reg_ch.valid <= 1'b0;
    reg_ch.data <= '0;
  end

  // result stall pattern, with one long hold-off on request
  initial begin
    logic [31:0] stall_bits;
    int unsigned run_left;
    int unsigned mode;
    bit          held;
    stall_bits = '1;
    run_left = 0;
    held = 1'b0;
    cell_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        cell_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      if (run_left == 0) begin
        mode = $urandom_range(0, 3);
        case (mode)
          0: stall_bits = '1;
          1: stall_bits = $urandom;
          2: stall_bits = $urandom | $urandom;
          default: stall_bits = $urandom & $urandom;
        endcase
        run_left = $urandom_range(16, 160);
      end
      cell_ch.ready <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[31:1]};
      run_left--;
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_ch.valid && cmd_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
          (reg_ch.valid && reg_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding", idle, pending);
    $display("status: fail");
    $finish;
  end

  function automatic in_data_t make_cmd(input logic [1:0] act, input logic [7:0] ch,
                                        input logic [7:0] at, input logic [4:0] row,
                                        input logic [6:0] col);
    in_data_t d;
    d.action = act;
    d.char_code = ch;
    d.attr = at;
    d.read_row = row;
    d.read_col = col;
    return d;
  endfunction

  function automatic in_data_t random_cmd(input int unsigned lf_weight);
    in_data_t d;
    int unsigned pick;
    int unsigned back;
    d.action = ACT_PUT;
    d.char_code = CHAR_W'($urandom);
    d.attr = ATTR_W'($urandom);
    d.read_row = RD_ROW_W'($urandom);
    d.read_col = RD_COL_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < lf_weight) begin
      d.char_code = CHAR_LF;
    end else if (pick < lf_weight + 5) begin
      d.char_code = CHAR_TAB;
    end else if (pick < lf_weight + 14) begin
      d.char_code = CHAR_BS;
    end else if (pick < lf_weight + 15) begin
      d.action = ($urandom_range(0, 2) == 0) ? ACT_CLEAR : ACT_SPARE;
    end else if (pick < lf_weight + 46) begin
      d.action = ACT_READ;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        back = $urandom_range(0, 2);
        if (back > 32'(hint_row)) back = 32'(hint_row);
        d.read_row = RD_ROW_W'(32'(hint_row) - back);
        d.read_col = RD_COL_W'($urandom_range(0, COLS_DEF - 1));
      end else if (pick < 9) begin
        d.read_row = RD_ROW_W'($urandom_range(0, ROWS_DEF - 1));
        d.read_col = RD_COL_W'($urandom_range(0, COLS_DEF - 1));
      end
    end
    return d;
  endfunction

  task automatic send_cmd(input in_data_t d);
    int unsigned gap;
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= d;
    do @(posedge clk_i); while (!cmd_ch.ready);
    burst_left--;
    sent_total++;
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_VAL_W-1:0] val);
    cfg_data_t cd;
    cd.index = idx;
    cd.value = val;
    reg_ch.valid <= 1'b1;
    reg_ch.data <= cd;
    do @(posedge clk_i); while (!reg_ch.ready);
    reg_writes++;
  endtask

  task automatic program_tabs(input logic [7:0] tab_color, input logic [7:0] tab_spaces);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_TAB_COLOR, tab_color);
      write_reg(REG_TAB_SPACES, tab_spaces);
    end else begin
      write_reg(REG_TAB_SPACES, tab_spaces);
      write_reg(REG_TAB_COLOR, tab_color);
    end
    reg_ch.valid <= 1'b0;
  endtask

  initial begin
    in_data_t    directed[$];
    logic [7:0]  phase_color [NUM_PHASES];
    logic [7:0]  phase_spaces [NUM_PHASES];
    int unsigned phase_lf [NUM_PHASES];

    phase_color  = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h07};
    phase_spaces = '{8'h01, 8'h08, 8'hF0, 8'h0F, 8'h00, 8'h04};
    phase_lf     = '{4, 12, 4, 15, 6, 4};
    phase_color[4] = 8'($urandom);
    phase_spaces[4] = {4'($urandom), 4'($urandom_range(1, 8))};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, CHAR_BS, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, 8'hFF, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, 8'h00, 8'hFF, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, CHAR_TAB, 8'h3C, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, CHAR_BS, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd5));
    directed.push_back(make_cmd(ACT_PUT, 8'h07, 8'h5A, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, CHAR_LF, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, CHAR_BS, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, 8'h41, 8'h1E, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd79));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd24, 7'd79));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd25, 7'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd80));
    directed.push_back(make_cmd(ACT_READ, 8'hFF, 8'hFF, 5'd31, 7'd127));
    directed.push_back(make_cmd(ACT_SPARE, 8'hFF, 8'hFF, 5'd31, 7'd127));
    directed.push_back(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    directed.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 5'd1, 7'd0));
    directed.push_back(make_cmd(ACT_PUT, 8'h0B, 8'hC3, 5'd0, 7'd0));
    foreach (directed[i]) send_cmd(directed[i]);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_tabs(phase_color[p], phase_spaces[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_cmd(random_cmd(phase_lf[p]));
        if (p == 1 && n == 70) hold_off_req <= 1'b1;
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d commands (%0d cell reads) and %0d screen scrolls",
             sent_total, reads, scrolls);
    $display("%0d results checked over %0d tab register writes, %0d mismatches",
             checked, reg_writes, fail_count);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
src/tcw_pkg.sv
src/tcw_stream_if.sv
src/tcw_front.sv
src/tcw_cmd_fifo.sv
src/tcw_back.sv
src/text_console_writer_unit.sv
tb/text_console_writer_checker.sv
tb/text_console_writer_unit_test.sv
